>>> design/pll_pkg.sv
// Package for the positional linked list engine: sizes, opcodes, status codes
// and the sequencer state type. No dependencies.
`default_nettype none
package pll_pkg;
    localparam int Capacity = 16;
    localparam int IdxW     = $clog2(Capacity);
    localparam int CntW     = $clog2(Capacity + 1);

    localparam logic [2:0] OP_PUSH_TAIL = 3'd0;
    localparam logic [2:0] OP_PUSH_HEAD = 3'd1;
    localparam logic [2:0] OP_INSERT    = 3'd2;
    localparam logic [2:0] OP_POP_TAIL  = 3'd3;
    localparam logic [2:0] OP_POP_HEAD  = 3'd4;
    localparam logic [2:0] OP_REMOVE    = 3'd5;
    localparam logic [2:0] OP_READ_ALL  = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_LINK  = 6'b000100,
        S_READ  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;
endpackage
`default_nettype wire

>>> design/pll_pool.sv
// Node pool for the linked list engine: value, next and prev memories with
// one write port each and registered read. Depends on pll_pkg.
`default_nettype none
module pll_pool (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire logic [pll_pkg::IdxW-1:0] wr_idx,
    input  wire logic [31:0]             wr_val,
    input  wire logic                    nx_we,
    input  wire logic [pll_pkg::IdxW-1:0] nx_idx,
    input  wire logic [pll_pkg::IdxW-1:0] nx_data,
    input  wire logic                    pv_we,
    input  wire logic [pll_pkg::IdxW-1:0] pv_idx,
    input  wire logic [pll_pkg::IdxW-1:0] pv_data,
    input  wire logic [pll_pkg::IdxW-1:0] rd_idx,
    output logic      [31:0]             rd_val,
    output logic      [pll_pkg::IdxW-1:0] rd_next,
    output logic      [pll_pkg::IdxW-1:0] rd_prev
);
    import pll_pkg::*;
    logic [31:0]     val_mem [Capacity];
    logic [IdxW-1:0] nx_mem  [Capacity];
    logic [IdxW-1:0] pv_mem  [Capacity];

    always_ff @(posedge aclk) begin
        if (wr_en) val_mem[wr_idx] <= wr_val;
        if (nx_we) nx_mem[nx_idx] <= nx_data;
        if (pv_we) pv_mem[pv_idx] <= pv_data;
        rd_val  <= val_mem[rd_idx];
        rd_next <= nx_mem[rd_idx];
        rd_prev <= pv_mem[rd_idx];
    end
endmodule
`default_nettype wire

>>> design/positional_linked_list_engine.sv
// Top level of the positional linked list engine: command sequencer, free
// stack and output register. Depends on pll_pkg and pll_pool.
`default_nettype none
// A command is taken only when the engine is idle and holds one transfer at a
// time. Push head and push tail into a non-empty list insert before the head.
// Positional insert walks the next links one node at a time through the
// single registered pool read port, as do positional remove and pop tail. A
// read-out emits one result per element. Every command ends with m_tlast high
// on its final result. No clearing pass is needed after reset.
module positional_linked_list_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero
    input  wire logic [2:0]  s_tuser,   // [2:0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // [31:0] item_value, [38:32] element_count, [39] zero
    output logic      [1:0]  m_tuser,   // [1:0] status
    output logic             m_tlast
);
    import pll_pkg::*;

    state_t            state_reg, state_next;
    logic [IdxW-1:0]   free_stack_reg [Capacity];
    logic [CntW-1:0]   free_top_reg;
    logic [IdxW-1:0]   head_reg;
    logic [CntW-1:0]   count_reg;
    logic              ins_reg;      // insert (1) or remove (0)
    logic              at_head_reg;  // inserted node becomes the head
    logic [31:0]       val_reg;
    logic [6:0]        pos_reg;      // target position, walk to it
    logic [6:0]        step_reg;     // nodes walked so far (1-based)
    logic [IdxW-1:0]   cur_reg;
    logic              rd_wait_reg;  // pool read in flight
    logic              link_ph_reg;  // second link write phase
    logic [IdxW-1:0]   node_reg;
    logic [IdxW-1:0]   pv_reg;
    logic [IdxW-1:0]   nx_reg;
    logic [31:0]       o_val_reg;
    logic [1:0]        o_st_reg;
    logic              o_last_reg;

    logic              wr_en, nx_we, pv_we;
    logic [IdxW-1:0]   wr_idx, nx_idx, nx_data, pv_idx, pv_data, rd_idx;
    logic [31:0]       rd_val;
    logic [IdxW-1:0]   rd_next, rd_prev;

    pll_pool u_pool (
        .aclk(aclk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_val(val_reg),
        .nx_we(nx_we), .nx_idx(nx_idx), .nx_data(nx_data),
        .pv_we(pv_we), .pv_idx(pv_idx), .pv_data(pv_data),
        .rd_idx(rd_idx), .rd_val(rd_val), .rd_next(rd_next), .rd_prev(rd_prev)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {1'b0, 7'(count_reg), o_val_reg};
    assign m_tuser  = o_st_reg;
    assign m_tlast  = o_last_reg;
    assign rd_idx   = cur_reg;

    // Link writes: an insert first writes the node and its own links, then joins it in.
    always_comb begin
        wr_en = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        wr_idx = node_reg; nx_idx = pv_reg; nx_data = node_reg;
        pv_idx = nx_reg; pv_data = node_reg;
        if (state_reg == S_LINK) begin
            if (ins_reg) begin
                if (!link_ph_reg) begin
                    wr_en = 1'b1;
                    nx_we = 1'b1; nx_idx = node_reg; nx_data = nx_reg;
                    pv_we = 1'b1; pv_idx = node_reg; pv_data = pv_reg;
                end else if (count_reg != '0) begin
                    nx_we = 1'b1; nx_idx = pv_reg; nx_data = node_reg;
                    pv_we = 1'b1; pv_idx = nx_reg; pv_data = node_reg;
                end
            end else begin
                nx_we = 1'b1; nx_idx = pv_reg; nx_data = nx_reg;
                pv_we = 1'b1; pv_idx = nx_reg; pv_data = pv_reg;
            end
        end
    end

    logic [6:0] cnt7;
    assign cnt7 = 7'(count_reg);

    // Command decode: status, walk target and first state of the sequence.
    logic            cmd_ins;
    logic            cmd_at_head;
    logic [6:0]      cmd_pos;
    logic [1:0]      cmd_st;
    state_t          cmd_state;
    logic [6:0]      s_pos;
    logic [IdxW-1:0] free_node;

    assign s_pos     = s_tdata[38:32];
    assign free_node = free_stack_reg[IdxW'(free_top_reg - 1'b1)];

    always_comb begin
        cmd_ins     = 1'b0;
        cmd_at_head = 1'b0;
        cmd_pos     = 7'd1;
        cmd_st      = ST_OK;
        cmd_state   = S_OUT;
        unique case (s_tuser)
            OP_PUSH_TAIL, OP_PUSH_HEAD, OP_INSERT: begin
                cmd_ins = 1'b1;
                // Tail position wraps to the head: insert before it.
                if (s_tuser == OP_INSERT && s_pos <= cnt7) cmd_pos = s_pos;
                cmd_at_head = (s_tuser == OP_PUSH_HEAD) ||
                              (s_tuser == OP_INSERT && s_pos == 7'd1);
                if (count_reg == CntW'(Capacity))
                    cmd_st = ST_FULL;
                else if (s_tuser == OP_INSERT &&
                         (s_pos == 7'd0 || s_pos > cnt7 + 7'd1))
                    cmd_st = ST_BADPOS;
                else if (count_reg == '0) cmd_state = S_LINK;
                else cmd_state = S_WALK;
            end
            OP_POP_TAIL, OP_POP_HEAD, OP_REMOVE: begin
                cmd_pos = (s_tuser == OP_POP_TAIL) ? cnt7 :
                          (s_tuser == OP_POP_HEAD) ? 7'd1 : s_pos;
                if (count_reg == '0) cmd_st = ST_EMPTY;
                else if (s_tuser == OP_REMOVE &&
                         (s_pos == 7'd0 || s_pos > cnt7))
                    cmd_st = ST_BADPOS;
                else cmd_state = S_WALK;
            end
            OP_READ_ALL: begin
                if (count_reg == '0) cmd_st = ST_EMPTY;
                else cmd_state = S_READ;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            free_top_reg <= CntW'(Capacity);
            head_reg     <= '0;
            count_reg    <= '0;
            for (int i = 0; i < Capacity; i++) free_stack_reg[i] <= IdxW'(i);
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    val_reg <= s_tdata[31:0];
                    cur_reg <= head_reg;
                    step_reg <= 7'd1;
                    rd_wait_reg <= 1'b1;
                    link_ph_reg <= 1'b0;
                    o_val_reg <= '0;
                    o_st_reg <= cmd_st;
                    o_last_reg <= 1'b1;
                    ins_reg <= cmd_ins;
                    at_head_reg <= cmd_at_head;
                    pos_reg <= cmd_pos;
                    node_reg <= free_node;
                    nx_reg <= free_node;
                    pv_reg <= free_node;
                    state_reg <= cmd_state;
                end
                S_WALK: begin
                    // Wait out the registered read, then advance or stop.
                    if (rd_wait_reg) rd_wait_reg <= 1'b0;
                    else if (step_reg < pos_reg) begin
                        cur_reg <= rd_next;
                        step_reg <= step_reg + 7'd1;
                        rd_wait_reg <= 1'b1;
                    end else begin
                        if (ins_reg) begin
                            nx_reg <= cur_reg;
                            pv_reg <= rd_prev;
                        end else begin
                            node_reg <= cur_reg;
                            nx_reg <= rd_next;
                            pv_reg <= rd_prev;
                            o_val_reg <= rd_val;
                        end
                        state_reg <= S_LINK;
                    end
                end
                S_LINK: begin
                    if (ins_reg && !link_ph_reg) link_ph_reg <= 1'b1;
                    else begin
                        if (ins_reg) begin
                            free_top_reg <= free_top_reg - 1'b1;
                            count_reg <= count_reg + 1'b1;
                            if (count_reg == '0 || at_head_reg) head_reg <= node_reg;
                        end else begin
                            free_stack_reg[IdxW'(free_top_reg)] <= node_reg;
                            free_top_reg <= free_top_reg + 1'b1;
                            count_reg <= count_reg - 1'b1;
                            if (count_reg == CntW'(1)) head_reg <= '0;
                            else if (pos_reg == 7'd1) head_reg <= nx_reg;
                        end
                        o_last_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_READ: state_reg <= S_EMIT;   // hold for the pool read
                S_EMIT: begin
                    o_val_reg <= rd_val;
                    o_last_reg <= (step_reg == cnt7);
                    cur_reg <= rd_next;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) begin
                    // Drop to idle on the last transfer, else fetch the next node.
                    if (o_last_reg) state_reg <= S_IDLE;
                    else begin
                        step_reg <= step_reg + 7'd1;
                        state_reg <= S_READ;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> tb/positional_linked_list_engine_tb.sv
// Self-checking testbench for the positional linked list engine: drives commands
// on the input stream, predicts every result and checks it. Depends on pll_pkg and the engine.
`default_nettype none
module positional_linked_list_engine_tb;
    import pll_pkg::*;

    // One expected result: value, status, element count and end-of-command flag.
    typedef struct packed {
        logic [31:0] item_value;
        logic [1:0]  status;
        logic [6:0]  element_count;
        logic        last;
    } list_result_t;

    int unsigned mismatch_count = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // List predictor and store of pending results.
    class list_scoreboard;
        logic [31:0]     node_val [Capacity];
        logic [IdxW-1:0] next_idx [Capacity];
        logic [IdxW-1:0] prev_idx [Capacity];
        logic [IdxW-1:0] free_idx [Capacity];
        int unsigned     free_top;
        logic [IdxW-1:0] head;
        int unsigned     count;
        list_result_t    pending_q[$];

        function new();
            for (int i = 0; i < Capacity; i++) begin
                free_idx[i] = i[IdxW-1:0];
                node_val[i] = '0;
                next_idx[i] = '0;
                prev_idx[i] = '0;
            end
            free_top = Capacity;
            head     = '0;
            count    = 0;
        endfunction

        function logic [IdxW-1:0] walk_to(input int unsigned pos);
            logic [IdxW-1:0] cur;
            cur = head;
            for (int s = 1; s < pos && s <= Capacity; s++) cur = next_idx[cur];
            return cur;
        endfunction

        function logic [1:0] insert_at(input logic [31:0] val, input int unsigned pos);
            logic [IdxW-1:0] n, at, pv;
            if (count >= Capacity || free_top == 0) return ST_FULL;
            if (pos < 1 || pos > count + 1) return ST_BADPOS;
            free_top--;
            n = free_idx[free_top];
            node_val[n] = val;
            if (count == 0) begin
                next_idx[n] = n;
                prev_idx[n] = n;
                head = n;
            end else begin
                // appending lands just before the head
                at = walk_to(pos > count ? 1 : pos);
                pv = prev_idx[at];
                next_idx[n] = at;
                prev_idx[n] = pv;
                next_idx[pv] = n;
                prev_idx[at] = n;
                if (pos == 1) head = n;
            end
            count++;
            return ST_OK;
        endfunction

        function logic [1:0] remove_at(input int unsigned pos, output logic [31:0] val);
            logic [IdxW-1:0] n, pv, nx;
            val = '0;
            if (count == 0) return ST_EMPTY;
            if (pos < 1 || pos > count) return ST_BADPOS;
            n = walk_to(pos);
            val = node_val[n];
            pv = prev_idx[n];
            nx = next_idx[n];
            next_idx[pv] = nx;
            prev_idx[nx] = pv;
            count--;
            if (count == 0) head = '0;
            else if (pos == 1) head = nx;
            if (free_top < Capacity) begin
                free_idx[free_top] = n;
                free_top++;
            end
            return ST_OK;
        endfunction

        function void note_command(input logic [2:0] op, input logic [31:0] val,
                                   input logic [6:0] pos);
            logic [31:0]     got;
            logic [1:0]      st;
            logic [IdxW-1:0] cur;
            got = '0;
            st  = ST_OK;
            case (op)
                OP_PUSH_TAIL: st = insert_at(val, count + 1);
                OP_PUSH_HEAD: st = insert_at(val, 1);
                OP_INSERT:    st = insert_at(val, pos);
                OP_POP_TAIL:  st = remove_at(count, got);
                OP_POP_HEAD:  st = remove_at(1, got);
                OP_REMOVE:    st = remove_at(pos, got);
                OP_READ_ALL: begin
                    if (count == 0) begin
                        pending_q.push_back('{'0, ST_EMPTY, 7'd0, 1'b1});
                    end else begin
                        cur = head;
                        for (int i = 0; i < count; i++) begin
                            pending_q.push_back('{node_val[cur], ST_OK, count[6:0],
                                                  (i + 1 == count)});
                            cur = next_idx[cur];
                        end
                    end
                    return;
                end
                default: st = ST_OK;
            endcase
            pending_q.push_back('{got, st, count[6:0], 1'b1});
        endfunction

        task check_result(input list_result_t seen);
            list_result_t want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", seen));
                return;
            end
            want = pending_q.pop_front();
            if (seen.item_value !== want.item_value)
                report_mismatch($sformatf("item_value %h, want %h",
                                          seen.item_value, want.item_value));
            if (seen.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", seen.status, want.status));
            if (seen.element_count !== want.element_count)
                report_mismatch($sformatf("element_count %0d, want %0d",
                                          seen.element_count, want.element_count));
            if (seen.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", seen.last, want.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [31:0] value, [38:32] position, [39] zero
    logic [2:0]  s_tuser;   // [2:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] item_value, [38:32] element_count, [39] zero
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;

    positional_linked_list_engine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    list_scoreboard list_sb = new();
    int unsigned    send_idle_pct  = 0;   // chance of a gap before each command
    int unsigned    recv_stall_pct = 0;   // chance of holding m_tready low
    int unsigned    quiet_cycles   = 0;
    localparam int unsigned QuietLimit = 4000;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: stall at random, check every result transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                list_sb.check_result('{m_tdata[31:0], m_tuser, m_tdata[38:32], m_tlast});
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("positional_linked_list_engine_tb: FAIL");
                $finish;
            end
        end
    end

    // Send one command, idling first at random; hold it until accepted.
    // tvalid stays high after the transfer until the next command or an idle gap replaces it.
    task automatic send_command(input logic [2:0] op, input logic [31:0] val,
                                input logic [6:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, pos, val};
        do @(posedge aclk); while (!s_tready);
        list_sb.note_command(op, val, pos);
    endtask

    // Random command; mostly fills toward mid-size lists with valid positions.
    task automatic send_random;
        logic [2:0]  op;
        logic [31:0] val;
        logic [6:0]  pos;
        int unsigned r;
        val = $urandom();
        r = $urandom_range(99);
        if (r < 8)       op = OP_READ_ALL;
        else if (r < 10) op = 3'd7;
        else if (list_sb.count < 4) op = 3'($urandom_range(2));
        else if (list_sb.count > 13) op = 3'(3 + $urandom_range(2));
        else op = 3'($urandom_range(5));
        // positions mostly in range, sometimes out of range or extreme
        r = $urandom_range(99);
        if (r < 80)      pos = 7'($urandom_range(list_sb.count + 1, 1));
        else if (r < 90) pos = 7'($urandom_range(127));
        else             pos = (r[0]) ? 7'd0 : 7'd127;
        send_command(op, val, pos);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty cases, extremes of values and positions, fill and drain.
        send_command(OP_READ_ALL, 32'd0, 7'd1);
        send_command(OP_POP_TAIL, 32'd0, 7'd1);
        send_command(OP_POP_HEAD, 32'd0, 7'd1);
        send_command(OP_REMOVE, 32'd0, 7'd1);
        send_command(OP_INSERT, 32'h1234_5678, 7'd2);
        send_command(OP_INSERT, 32'h8000_0000, 7'd1);
        send_command(OP_PUSH_TAIL, 32'h7FFF_FFFF, 7'd0);
        send_command(OP_PUSH_HEAD, 32'hFFFF_FFFF, 7'd127);
        send_command(OP_INSERT, 32'h0000_0000, 7'd4);
        send_command(OP_INSERT, 32'hAAAA_5555, 7'd2);
        send_command(OP_REMOVE, 32'd0, 7'd0);
        send_command(OP_REMOVE, 32'd0, 7'd6);
        send_command(3'd7, 32'h5555_AAAA, 7'h55);
        send_command(OP_READ_ALL, 32'd0, 7'd0);
        for (int i = 0; i < 13; i++) send_command(OP_PUSH_TAIL, $urandom(), 7'd1);
        send_command(OP_PUSH_HEAD, 32'd1, 7'd1);
        send_command(OP_INSERT, 32'd2, 7'd100);
        send_command(OP_READ_ALL, 32'd0, 7'd1);
        send_command(OP_REMOVE, 32'd0, 7'd16);
        send_command(OP_REMOVE, 32'd0, 7'd1);
        send_command(OP_POP_TAIL, 32'd0, 7'd1);
        send_command(OP_POP_HEAD, 32'd0, 7'd1);
        while (list_sb.count > 0) send_command(OP_POP_HEAD, 32'd0, 7'd1);

        // Random phases with different idling.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                3: begin send_idle_pct = 18; recv_stall_pct = 18; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 88; i++) send_random();
        end
        s_tvalid <= 1'b0;

        while (list_sb.pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && list_sb.pending_q.size() == 0)
            $display("positional_linked_list_engine_tb: PASS");
        else
            $display("positional_linked_list_engine_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
design/pll_pkg.sv
design/pll_pool.sv
design/positional_linked_list_engine.sv
tb/positional_linked_list_engine_tb.sv
